>>> src/lcg_random_int_and_fraction_macros.svh
// Assertion helpers for the top-level RTL
`ifndef LCG_RANDOM_INT_AND_FRACTION_MACROS_SVH
`define LCG_RANDOM_INT_AND_FRACTION_MACROS_SVH

// same-cycle implication, checked outside reset
`define LRIF_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LRIF_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> src/lrif_pkg.sv
`default_nettype none

package lrif_pkg;

   localparam logic [31:0] LCG_MUL    = 32'd1664525;
   localparam logic [31:0] LCG_ADD    = 32'd1013904223;
   localparam int          INT_W      = 15;
   localparam int          FRAC_W     = 24;
   localparam int          SEED_W     = 32;
   localparam logic [4:0]  SHIFT_BASE = 5'd16;

   // request kinds
   localparam logic OP_INT  = 1'b0;
   localparam logic OP_FRAC = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DIV,
      ST_DONE
   } seq_state_type;

   // control from the sequencer to the generator
   typedef struct packed {
      logic load;
      logic step;
   } lcg_ctrl_type;

   // number of significant bits of a 15-bit value (0 for zero)
   function automatic logic [3:0] bit_length(input logic [INT_W-1:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < INT_W; i++) begin
         if (v[i]) begin
            n = 4'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

>>> src/lcg_random_int_and_fraction.sv
// Integer request: generator step (multiply, then add), then the remainder loop,
//   then the result register; fraction request: generator step, then the result
//   register; integer request with zero bound: straight to the result register.
// Throughput: one request at a time; the next request is accepted once the result
//   of the last one is loaded, which waits while the result side is stalled.
// Reset: synchronous, active high; generator state goes to 0, channels idle.
`default_nettype none
`include "lcg_random_int_and_fraction_macros.svh"

module lcg_random_int_and_fraction
   import lrif_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [14:0] max_value, [15] signed_range
   input  wire logic        req_tuser,  // [0] opcode
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,  // [14:0] int_value, [38:15] fraction_value,
                                        // [70:39] seed_now, [71] zero
   // seed register write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   seq_state_type     state_ff, state_in;
   logic              op_ff;
   logic [INT_W-1:0]  max_ff;
   logic              sgn_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [INT_W-1:0]  int_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [SEED_W-1:0] seed_ff;

   lcg_ctrl_type      lcg_ctrl;
   logic [SEED_W-1:0] gen_state;
   logic              lcg_done;
   logic              div_start;
   logic              div_busy;
   logic              div_done;
   logic [INT_W-1:0]  div_rem;
   logic [INT_W-1:0]  dividend;
   logic [3:0]        shift;
   logic              req_fire;
   logic              out_load;
   logic [INT_W-1:0]  int_next;
   logic [FRAC_W-1:0] frac_next;

   assign req_fire = req_tvalid && req_tready;

   // low 15 state bits scaled down to one bit under the bound's bit length
   assign shift    = 4'(SHIFT_BASE - {1'b0, bit_length(max_ff)});
   assign dividend = gen_state[INT_W-1:0] >> shift;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_tready    = 1'b0;
      csr_ready     = 1'b0;
      lcg_ctrl.load = 1'b0;
      lcg_ctrl.step = 1'b0;
      div_start     = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            csr_ready     = 1'b1;
            req_tready    = !csr_valid;
            lcg_ctrl.load = csr_valid;
            if (req_fire) begin
               if (req_tuser == OP_INT && req_tdata[INT_W-1:0] == '0) begin
                  state_in = ST_DONE;
               end else begin
                  lcg_ctrl.step = 1'b1;
                  state_in      = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (lcg_done) begin
               if (op_ff == OP_INT) begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_tuser;
         max_ff <= req_tdata[INT_W-1:0];
         sgn_ff <= req_tdata[INT_W];
      end
   end

   // result fields
   always_comb begin
      int_next  = '0;
      frac_next = '0;
      if (op_ff == OP_INT) begin
         if (max_ff != '0) begin
            int_next = div_rem;
         end
      end else if (sgn_ff) begin
         // 2m - 2^23 in 24 bits
         frac_next = {~gen_state[22], gen_state[21:0], 1'b0};
      end else begin
         frac_next = {1'b0, gen_state[22:0]};
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         int_ff  <= int_next;
         frac_ff <= frac_next;
         seed_ff <= gen_state;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, seed_ff, frac_ff, int_ff};

   lrif_lcg u_lcg (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (lcg_ctrl),
      .load_value (csr_data),
      .state_now  (gen_state),
      .done       (lcg_done)
   );

   lrif_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend),
      .divisor   (max_ff),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   // checks
   `LRIF_ASSERT_SAME(a_int_below_bound, clock, reset,
      out_load && op_ff == OP_INT && max_ff != '0, int_next < max_ff,
      "integer result not below its bound")
   `LRIF_ASSERT_SAME(a_div_only_in_div, clock, reset,
      div_busy, state_ff == ST_DIV, "remainder unit running outside its state")
   `LRIF_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req_fire, state_ff != ST_IDLE, "sequencer stayed idle after a transfer")
   `LRIF_ASSERT_SAME(a_int_no_fraction, clock, reset,
      out_load && op_ff == OP_INT, frac_next == '0, "integer result carries a fraction")

endmodule

`default_nettype wire

>>> src/lrif_lcg.sv
`default_nettype none

// Generator state with a registered step: multiply into a product register, then add
module lrif_lcg
   import lrif_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lcg_ctrl_type      ctrl,
   input  wire logic [SEED_W-1:0] load_value,
   output logic      [SEED_W-1:0] state_now,
   output logic                   done
);

   logic [SEED_W-1:0] state_ff, state_in;
   logic [SEED_W-1:0] prod_ff;
   logic              phase_ff, phase_in;
   logic              done_ff, done_in;

   // next state: a load wins over a step
   always_comb begin
      state_in = state_ff;
      phase_in = 1'b0;
      done_in  = 1'b0;
      if (ctrl.load) begin
         state_in = load_value;
      end else if (phase_ff) begin
         state_in = prod_ff + LCG_ADD;
         done_in  = 1'b1;
      end else if (ctrl.step) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // product register, mod 2^32
   always_ff @(posedge clock) begin
      prod_ff <= state_ff * LCG_MUL;
   end

   assign state_now = state_ff;
   assign done      = done_ff;

endmodule

`default_nettype wire

>>> src/lrif_div.sv
`default_nettype none

// Radix-2 restoring remainder unit, one bit per cycle
module lrif_div
   import lrif_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [INT_W-1:0] dividend,
   input  wire logic [INT_W-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic      [INT_W-1:0] remainder
);

   logic [INT_W-1:0] quo_ff, quo_in;
   logic [INT_W-1:0] rem_ff, rem_in;
   logic [INT_W-1:0] dsr_ff, dsr_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [INT_W:0]   trial;
   logic [INT_W:0]   diff;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      trial   = {rem_ff, quo_ff[INT_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 4'(INT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[INT_W-2:0], 1'b0};
         rem_in = diff[INT_W] ? trial[INT_W-1:0] : diff[INT_W-1:0];
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
   import lrif_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 30;

   // one expected response, one member per result field
   typedef struct packed {
      logic [14:0] int_value;
      logic [23:0] fraction_value;
      logic [31:0] seed_now;
   } rng_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;  // [14:0] max_value, [15] signed_range
   logic        req_tuser  = 1'b0; // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;  // [14:0] int_value, [38:15] fraction_value, [70:39] seed_now
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;

   // testbench state
   logic        idle_on    = 1'b0;
   logic        hold_start = 1'b0;
   logic [31:0] lcg_state  = '0;
   rng_result_type rng_expected_q[$];
   int          fail_count = 0;
   int          hold_left  = 0;
   int          stall_left = 0;
   int          quiet_cycles = 0;

   lcg_random_int_and_fraction dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // step the generator copy and queue the response it implies
   task automatic predict_rng(input logic op, input logic [14:0] bound, input logic sgn);
      rng_result_type exp_r;
      int          blen;
      logic [31:0] shifted;
      logic [31:0] twice;
      exp_r = '0;
      if (op == OP_INT) begin
         // zero bound: no step, value stays 0
         if (bound != 15'd0) begin
            lcg_state = lcg_state * LCG_MUL + LCG_ADD;
            blen = $clog2(int'(bound) + 1);
            shifted = {17'd0, lcg_state[14:0]} >> (16 - blen);
            exp_r.int_value = 15'(shifted % {17'd0, bound});
         end
      end else begin
         lcg_state = lcg_state * LCG_MUL + LCG_ADD;
         twice = {8'd0, lcg_state[22:0], 1'b0};
         if (sgn) begin
            exp_r.fraction_value = 24'(twice - 32'h0080_0000);
         end else begin
            exp_r.fraction_value = {1'b0, lcg_state[22:0]};
         end
      end
      exp_r.seed_now = lcg_state;
      rng_expected_q.push_back(exp_r);
   endtask

   // offer one request; valid stays up for a following request unless a gap is taken
   task automatic send_req(input logic op, input logic [14:0] bound, input logic sgn);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sgn, bound};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_rng(op, bound, sgn);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_random_req();
      int          pick;
      logic [14:0] bound;
      pick  = $urandom_range(0, 99);
      bound = 15'($urandom());
      if ($urandom_range(0, 2) == 0) begin
         send_req(OP_FRAC, bound, 1'($urandom()));
      end else begin
         if (pick < 15) begin
            bound = 15'($urandom_range(1, 16));
         end else if (pick < 20) begin
            bound = 15'd0;
         end else if (pick < 30) begin
            bound = 15'(1 << $urandom_range(0, 14));
            if ($urandom_range(0, 1) == 1 && bound != 15'd1) bound = bound - 15'd1;
         end
         send_req(OP_INT, bound, 1'($urandom()));
      end
   endtask

   // stop offering and wait until every expected response has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rng_expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // seed load, only with the block idle
   task automatic write_seed(input logic [31:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      lcg_state = value;
   endtask

   // generator from reset value, no seed write yet
   task automatic test_reset_seed();
      send_req(OP_INT, 15'd100, 1'b0);
      send_req(OP_FRAC, 15'd0, 1'b0);
      send_req(OP_FRAC, 15'd0, 1'b1);
   endtask

   // bound extremes, zero bound, ignored fields, both fraction forms
   task automatic test_bound_extremes();
      write_seed(32'hFFFF_FFFF);
      send_req(OP_INT, 15'd0, 1'b0);
      send_req(OP_INT, 15'd1, 1'b1);
      send_req(OP_INT, 15'd2, 1'b0);
      send_req(OP_INT, 15'h7FFF, 1'b1);
      send_req(OP_INT, 15'h4000, 1'b0);
      send_req(OP_INT, 15'h3FFF, 1'b0);
      send_req(OP_INT, 15'h5555, 1'b1);
      send_req(OP_INT, 15'h2AAA, 1'b0);
      send_req(OP_FRAC, 15'h7FFF, 1'b0);
      send_req(OP_FRAC, 15'h7FFF, 1'b1);
      send_req(OP_FRAC, 15'd0, 1'b1);
      send_req(OP_INT, 15'd0, 1'b1);
   endtask

   // seed register extremes
   task automatic test_seed_extremes();
      write_seed(32'h0000_0000);
      send_req(OP_INT, 15'd0, 1'b0);
      send_req(OP_FRAC, 15'd1, 1'b1);
      write_seed(32'h8000_0000);
      send_req(OP_INT, 15'h7FFF, 1'b0);
      send_req(OP_FRAC, 15'd0, 1'b0);
      write_seed(32'h0000_0001);
      send_req(OP_INT, 15'd3, 1'b0);
      send_req(OP_FRAC, 15'd0, 1'b1);
   endtask

   // long response hold-off while requests keep coming
   task automatic test_result_backpressure();
      write_seed($urandom());
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      repeat (8) send_random_req();
   endtask

   // sender pauses mid-stream until all responses are back
   task automatic test_sender_pause();
      repeat (20) send_random_req();
      drain_results();
      repeat (20) send_random_req();
   endtask

   // random traffic in phases with new seeds; the third and last phases run without gaps
   task automatic test_random_phases();
      logic [31:0] seed_pick;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            1: seed_pick = 32'hFFFF_FFFF;
            3: seed_pick = 32'h0000_0000;
            default: seed_pick = $urandom();
         endcase
         write_seed(seed_pick);
         idle_on <= (phase == 0 || phase == 1 || phase == 3);
         repeat (300) send_random_req();
      end
   endtask

   // response side: random stalls plus the long hold-off when requested
   always @(posedge clock) begin
      if (hold_start && hold_left == 0) hold_left = LONG_HOLD;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each response transfer with the oldest prediction
   always @(posedge clock) begin
      rng_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rng_expected_q.size() == 0) begin
            $error("unexpected response, tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_r = rng_expected_q.pop_front();
            if (rsp_tdata[14:0] !== exp_r.int_value) begin
               $error("int_value: expected %0d, got %0d", exp_r.int_value, rsp_tdata[14:0]);
               fail_count++;
            end
            if (rsp_tdata[38:15] !== exp_r.fraction_value) begin
               $error("fraction_value: expected %0d, got %0d",
                      $signed(exp_r.fraction_value), $signed(rsp_tdata[38:15]));
               fail_count++;
            end
            if (rsp_tdata[70:39] !== exp_r.seed_now) begin
               $error("seed_now: expected %h, got %h", exp_r.seed_now, rsp_tdata[70:39]);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[lcg_random_int_and_fraction] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_on <= 1'b1;
      test_reset_seed();
      test_bound_extremes();
      test_seed_extremes();
      test_result_backpressure();
      test_sender_pause();
      test_random_phases();
      drain_results();
      if (rng_expected_q.size() != 0) begin
         $error("%0d responses never arrived", rng_expected_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("[lcg_random_int_and_fraction] OK");
      end else begin
         $display("[lcg_random_int_and_fraction] ERROR");
      end
      $finish;
   end

endmodule
